/* hw/rtl/i2cts_pkg.sv */
// ---------------------------------------------------------------------------
// i2cts_pkg
// Shared types and constants for the temperature sensor read sequencer.
// ---------------------------------------------------------------------------
package i2cts_pkg;

    // Controller status codes
    localparam logic [7:0] STATUS_START     = 8'h08;
    localparam logic [7:0] STATUS_ADDR_ACK  = 8'h40;
    localparam logic [7:0] STATUS_ADDR_NACK = 8'h48;
    localparam logic [7:0] STATUS_DATA_ACK  = 8'h50;
    localparam logic [7:0] STATUS_DATA_NACK = 8'h58;

    // Control register bit groups
    localparam logic [7:0] CON_NONE         = 8'h00;
    localparam logic [7:0] CON_ACK          = 8'h04;
    localparam logic [7:0] CON_INT          = 8'h08;
    localparam logic [7:0] CON_ACK_INT      = 8'h0C;
    localparam logic [7:0] CON_STOP_ACK     = 8'h14;
    localparam logic [7:0] CON_START_INT    = 8'h28;

    localparam logic [7:0] READ_ADDR_RESET  = 8'h91;
    localparam logic [7:0] RELOAD_BYTE0     = 8'hCD;
    localparam logic [7:0] RELOAD_BYTE1     = 8'h05;

    localparam int         BUFFER_BYTES     = 2;
    localparam logic [1:0] COUNT_FULL       = 2'(BUFFER_BYTES);

    localparam logic [5:0] ASCII_ZERO       = 6'd48;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] count;
    } rx_state_t;

    typedef struct packed {
        logic [5:0] int_tens_char;
        logic [5:0] int_ones_char;
        logic [5:0] frac_hund_char;
        logic [5:0] frac_tens_char;
        logic [5:0] frac_ones_char;
    } digits_t;

    typedef struct packed {
        logic [7:0]  con_set;
        logic [7:0]  con_clr;
        logic        tx_load;
        logic [7:0]  tx_byte;
        logic        reading_valid;
        logic [17:0] temp_milli;
        digits_t     digits;
    } result_t;

endpackage

/* hw/rtl/i2cts_format.sv */
// ---------------------------------------------------------------------------
// i2cts_format
// Scales the buffered reading to millidegrees and produces its ASCII digits.
// ---------------------------------------------------------------------------
module i2cts_format (
    input  logic [7:0]        byte0,
    input  logic [7:0]        byte1,
    output logic [17:0]       temp_milli,
    output i2cts_pkg::digits_t digits
);
    import i2cts_pkg::*;

    logic [10:0] reading;
    logic [2:0]  eighths;
    logic [15:0] recip_prod;
    logic [4:0]  quot10;
    logic [7:0]  ones_val;
    logic [4:0]  tens_val;
    logic [3:0]  frac_hund;
    logic [3:0]  frac_tens;
    logic [3:0]  frac_ones;

    assign reading    = {byte0, byte1[7:5]};
    assign temp_milli = 18'(reading) * 18'd125;

    // Whole degrees are reading / 8, which is exactly byte0, and the
    // remainder in millidegrees is the low three bits times 125.
    assign eighths = byte1[7:5];

    // Division of an eight-bit value by ten through a reciprocal multiply.
    assign recip_prod = 16'(byte0) * 16'd205;
    assign quot10     = recip_prod[15:11];
    assign ones_val   = byte0 - 8'(8'(quot10) * 8'd10);

    always_comb
    begin
        if (quot10 >= 5'd20)
        begin
            tens_val = quot10 - 5'd20;
        end
        else if (quot10 >= 5'd10)
        begin
            tens_val = quot10 - 5'd10;
        end
        else
        begin
            tens_val = quot10;
        end
    end

    always_comb
    begin
        unique case (eighths)
            3'd0:
            begin
                frac_hund = 4'd0; frac_tens = 4'd0; frac_ones = 4'd0;
            end
            3'd1:
            begin
                frac_hund = 4'd1; frac_tens = 4'd2; frac_ones = 4'd5;
            end
            3'd2:
            begin
                frac_hund = 4'd2; frac_tens = 4'd5; frac_ones = 4'd0;
            end
            3'd3:
            begin
                frac_hund = 4'd3; frac_tens = 4'd7; frac_ones = 4'd5;
            end
            3'd4:
            begin
                frac_hund = 4'd5; frac_tens = 4'd0; frac_ones = 4'd0;
            end
            3'd5:
            begin
                frac_hund = 4'd6; frac_tens = 4'd2; frac_ones = 4'd5;
            end
            3'd6:
            begin
                frac_hund = 4'd7; frac_tens = 4'd5; frac_ones = 4'd0;
            end
            default:
            begin
                frac_hund = 4'd8; frac_tens = 4'd7; frac_ones = 4'd5;
            end
        endcase
    end

    assign digits.int_tens_char  = ASCII_ZERO + 6'(tens_val);
    assign digits.int_ones_char  = ASCII_ZERO + 6'(ones_val[3:0]);
    assign digits.frac_hund_char = ASCII_ZERO + 6'(frac_hund);
    assign digits.frac_tens_char = ASCII_ZERO + 6'(frac_tens);
    assign digits.frac_ones_char = ASCII_ZERO + 6'(frac_ones);

endmodule

/* hw/rtl/i2cts_step.sv */
// ---------------------------------------------------------------------------
// i2cts_step
// Decodes one status event into control actions and the next buffer state.
// ---------------------------------------------------------------------------
module i2cts_step (
    input  logic [7:0]           status_code,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           read_addr,
    input  i2cts_pkg::rx_state_t state,
    output i2cts_pkg::rx_state_t state_next,
    output i2cts_pkg::result_t   result
);
    import i2cts_pkg::*;

    logic [17:0] fmt_milli;
    digits_t     fmt_digits;
    logic [1:0]  count_inc;

    i2cts_format u_format (
        .byte0      (state.byte0),
        .byte1      (state.byte1),
        .temp_milli (fmt_milli),
        .digits     (fmt_digits)
    );

    assign count_inc = state.count + 2'd1;

    always_comb
    begin
        state_next = state;
        result     = '0;
        unique case (status_code)
            STATUS_START:
            begin
                result.tx_load = 1'b1;
                result.tx_byte = read_addr;
                result.con_clr = CON_START_INT;
            end
            STATUS_ADDR_NACK:
            begin
                result.con_clr = CON_START_INT;
            end
            STATUS_ADDR_ACK:
            begin
                result.con_set = CON_ACK;
                result.con_clr = CON_INT;
            end
            STATUS_DATA_ACK:
            begin
                if (state.count < COUNT_FULL)
                begin
                    if (state.count[0])
                    begin
                        state_next.byte1 = rx_byte;
                    end
                    else
                    begin
                        state_next.byte0 = rx_byte;
                    end
                    state_next.count = count_inc;
                end
                // Keep acknowledging until the buffer has just filled.
                if (state_next.count < COUNT_FULL)
                begin
                    result.con_set = CON_ACK;
                    result.con_clr = CON_INT;
                end
                else
                begin
                    result.con_clr = CON_ACK_INT;
                end
            end
            STATUS_DATA_NACK:
            begin
                result.con_set       = CON_STOP_ACK;
                result.con_clr       = CON_INT;
                result.reading_valid = 1'b1;
                result.temp_milli    = fmt_milli;
                result.digits        = fmt_digits;
                state_next.byte0     = RELOAD_BYTE0;
                state_next.byte1     = RELOAD_BYTE1;
                state_next.count     = 2'd0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/i2c_temp_sensor_read_sequencer.sv */
// Each status event is captured in the input register and its result is
// registered in the result register before it is shown on the master side.
// Throughput: one status event per cycle unless the master side stalls; the
// input register refills in the same cycle as its item moves to the result
// register. Reset clears the receive buffer, byte count and both valid flags,
// and sets the slave address register to 0x91.
// ---------------------------------------------------------------------------
// i2c_temp_sensor_read_sequencer
// I2C master sequencer for a two-byte temperature read, one status per item.
// ---------------------------------------------------------------------------
module i2c_temp_sensor_read_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // slave_address_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // rx_byte
    input  logic [7:0]  s_tuser,       // status_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // con_set, con_clr, tx_byte, temp_milli,
                                       // int_tens, int_ones, frac_hund,
                                       // frac_tens, frac_ones chars
    output logic [1:0]  m_tuser        // tx_load, reading_valid
);
    import i2cts_pkg::*;

    logic      in_valid_reg;
    logic [7:0] in_status_reg;
    logic [7:0] in_rx_reg;
    logic      out_valid_reg;
    result_t   out_reg;
    result_t   result_next;
    rx_state_t state_reg;
    rx_state_t state_next;
    logic [7:0] read_addr_reg;
    logic      advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    i2cts_step u_step (
        .status_code (in_status_reg),
        .rx_byte     (in_rx_reg),
        .read_addr   (read_addr_reg),
        .state       (state_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            read_addr_reg <= READ_ADDR_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                read_addr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_status_reg <= s_tuser;
            in_rx_reg     <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.digits.frac_ones_char, out_reg.digits.frac_tens_char,
                       out_reg.digits.frac_hund_char, out_reg.digits.int_ones_char,
                       out_reg.digits.int_tens_char, out_reg.temp_milli,
                       out_reg.tx_byte, out_reg.con_clr, out_reg.con_set};
    assign m_tuser  = {out_reg.reading_valid, out_reg.tx_load};

endmodule

/* hw/rtl/i2cts_checker.sv */
// ---------------------------------------------------------------------------
// i2cts_checker
// Port-level checks for the temperature sensor read sequencer.
// ---------------------------------------------------------------------------
module i2cts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import i2cts_pkg::*;

    // A stalled result holds until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A reading comes only with the stop request.
    a_reading_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |->
            m_tdata[7:0] == CON_STOP_ACK && m_tdata[15:8] == CON_INT && !m_tuser[0])
        else $error("reading without stop control");

    // Loading the address byte only happens on the start status.
    a_tx_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tdata[15:8] == CON_START_INT && m_tdata[7:0] == CON_NONE)
        else $error("address load without start control");

    // Without a reading the temperature and digit fields stay clear.
    a_no_reading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[71:24] == '0)
        else $error("reading fields set without a reading");

    // Every digit of a reading is an ASCII decimal character.
    a_digits_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |->
            m_tdata[47:42] >= 6'd48 && m_tdata[47:42] <= 6'd57 &&
            m_tdata[53:48] >= 6'd48 && m_tdata[53:48] <= 6'd57 &&
            m_tdata[59:54] >= 6'd48 && m_tdata[59:54] <= 6'd57 &&
            m_tdata[65:60] >= 6'd48 && m_tdata[65:60] <= 6'd57 &&
            m_tdata[71:66] >= 6'd48 && m_tdata[71:66] <= 6'd57)
        else $error("digit outside decimal range");

endmodule

bind i2c_temp_sensor_read_sequencer i2cts_checker u_i2cts_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C temperature sensor read sequencer. Status
// events are streamed in, partly as directed cases and mostly as well-formed
// read transactions with random content. Each response is checked field by
// field against a scoreboard that tracks the receive buffer and the address
// register.
// ---------------------------------------------------------------------------
import i2cts_pkg::*;

class read_scoreboard;
    logic [7:0] read_addr;
    logic [7:0] rx_bytes [BUFFER_BYTES];
    logic [1:0] rx_count;
    result_t    expected_responses [$];
    int         errors;

    function new();
        read_addr = READ_ADDR_RESET;
        rx_bytes[0] = 8'h00;
        rx_bytes[1] = 8'h00;
        rx_count = 2'd0;
        errors = 0;
    endfunction

    function void set_address(logic [7:0] value);
        read_addr = value;
    endfunction

    // Works out the response to one status transfer and updates the buffer.
    function void note_status(logic [7:0] status, logic [7:0] rx);
        result_t     r;
        int unsigned reading;
        int unsigned milli;
        int unsigned whole;
        int unsigned frac;
        r = '0;
        case (status)
            STATUS_START:
            begin
                r.tx_load = 1'b1;
                r.tx_byte = read_addr;
                r.con_clr = CON_START_INT;
            end
            STATUS_ADDR_NACK:
            begin
                r.con_clr = CON_START_INT;
            end
            STATUS_ADDR_ACK:
            begin
                r.con_set = CON_ACK;
                r.con_clr = CON_INT;
            end
            STATUS_DATA_ACK:
            begin
                // Once the buffer is full, further bytes are dropped.
                if (rx_count < COUNT_FULL)
                begin
                    rx_bytes[rx_count] = rx;
                    rx_count = rx_count + 2'd1;
                end
                if (rx_count < COUNT_FULL)
                begin
                    r.con_set = CON_ACK;
                    r.con_clr = CON_INT;
                end
                else
                begin
                    r.con_clr = CON_ACK_INT;
                end
            end
            STATUS_DATA_NACK:
            begin
                reading = ({24'd0, rx_bytes[0]} << 3) | ({24'd0, rx_bytes[1]} >> 5);
                reading = reading & 32'h7FF;
                milli = reading * 125;
                whole = milli / 1000;
                frac = milli % 1000;
                r.con_set = CON_STOP_ACK;
                r.con_clr = CON_INT;
                r.reading_valid = 1'b1;
                r.temp_milli = milli[17:0];
                r.digits.int_tens_char = ASCII_ZERO + 6'((whole / 10) % 10);
                r.digits.int_ones_char = ASCII_ZERO + 6'(whole % 10);
                r.digits.frac_hund_char = ASCII_ZERO + 6'((frac / 100) % 10);
                r.digits.frac_tens_char = ASCII_ZERO + 6'((frac / 10) % 10);
                r.digits.frac_ones_char = ASCII_ZERO + 6'(frac % 10);
                rx_bytes[0] = RELOAD_BYTE0;
                rx_bytes[1] = RELOAD_BYTE1;
                rx_count = 2'd0;
            end
            default:
            begin
            end
        endcase
        expected_responses.push_back(r);
    endfunction

    function void check_field(string name, logic [17:0] exp_val, logic [17:0] act_val);
        if (act_val !== exp_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endfunction

    function void check_response(logic [71:0] data, logic [1:0] user);
        result_t act;
        result_t exp_r;
        act.con_set = data[7:0];
        act.con_clr = data[15:8];
        act.tx_byte = data[23:16];
        act.temp_milli = data[41:24];
        act.digits.int_tens_char = data[47:42];
        act.digits.int_ones_char = data[53:48];
        act.digits.frac_hund_char = data[59:54];
        act.digits.frac_tens_char = data[65:60];
        act.digits.frac_ones_char = data[71:66];
        act.tx_load = user[0];
        act.reading_valid = user[1];
        if (expected_responses.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h/%h",
                     $time, data, user);
        end
        else
        begin
            exp_r = expected_responses.pop_front();
            check_field("con_set", 18'(exp_r.con_set), 18'(act.con_set));
            check_field("con_clr", 18'(exp_r.con_clr), 18'(act.con_clr));
            check_field("tx_load", 18'(exp_r.tx_load), 18'(act.tx_load));
            check_field("tx_byte", 18'(exp_r.tx_byte), 18'(act.tx_byte));
            check_field("reading_valid", 18'(exp_r.reading_valid),
                        18'(act.reading_valid));
            check_field("temp_milli", exp_r.temp_milli, act.temp_milli);
            check_field("int_tens_char", 18'(exp_r.digits.int_tens_char),
                        18'(act.digits.int_tens_char));
            check_field("int_ones_char", 18'(exp_r.digits.int_ones_char),
                        18'(act.digits.int_ones_char));
            check_field("frac_hund_char", 18'(exp_r.digits.frac_hund_char),
                        18'(act.digits.frac_hund_char));
            check_field("frac_tens_char", 18'(exp_r.digits.frac_tens_char),
                        18'(act.digits.frac_tens_char));
            check_field("frac_ones_char", 18'(exp_r.digits.frac_ones_char),
                        18'(act.digits.frac_ones_char));
        end
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 217;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [7:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    read_scoreboard board;
    int             send_idle;
    int             recv_idle;
    int             quiet_cycles;
    int             items_sent;

    i2c_temp_sensor_read_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Observe every transfer at the rising edge, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_response(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                board.note_status(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                board.set_address(cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_status(input logic [7:0] status, input logic [7:0] rx);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= status;
        s_tdata <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Holds the input back until every response has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_address(input logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One read transaction, mostly well formed; some are noise or cut short.
    task automatic send_transaction();
        int pick;
        int data_bytes;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            send_status(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        else
        begin
            send_status(STATUS_START, 8'($urandom_range(255)));
            if (pick < 18)
            begin
                send_status(STATUS_ADDR_NACK, 8'($urandom_range(255)));
            end
            else
            begin
                send_status(STATUS_ADDR_ACK, 8'($urandom_range(255)));
                data_bytes = ($urandom_range(99) < 75) ? 2 : $urandom_range(3);
                repeat (data_bytes)
                    send_status(STATUS_DATA_ACK, 8'($urandom_range(255)));
                send_status(STATUS_DATA_NACK, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input int sidle, input int ridle, input logic [7:0] addr);
        int target;
        write_address(addr);
        send_idle = sidle;
        recv_idle = ridle;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            send_transaction();
            if (items_sent >= target - PHASE_ITEMS / 2 && items_sent < target - PHASE_ITEMS / 2 + 4)
                wait_drained();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 8'h00;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 8'h00;
        m_tready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        quiet_cycles = 0;
        items_sent = 0;
        board = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed cases with the address register at its reset value.
        send_idle = 20;
        recv_idle = 20;
        send_status(STATUS_DATA_NACK, 8'hA5);     // reading from the cleared buffer
        send_status(STATUS_START, 8'h00);
        send_status(STATUS_ADDR_NACK, 8'hFF);
        send_status(STATUS_START, 8'hFF);
        send_status(STATUS_ADDR_ACK, 8'h00);
        send_status(STATUS_DATA_ACK, 8'hFF);
        send_status(STATUS_DATA_ACK, 8'hE0);
        send_status(STATUS_DATA_ACK, 8'h00);      // buffer already full
        send_status(STATUS_DATA_NACK, 8'h00);     // largest reading
        send_status(STATUS_DATA_NACK, 8'hFF);     // reading from the reloaded bytes
        send_status(STATUS_DATA_ACK, 8'h00);
        send_status(STATUS_DATA_ACK, 8'h1F);
        send_status(STATUS_DATA_NACK, 8'h00);     // smallest reading
        send_status(STATUS_DATA_ACK, 8'h55);      // only one byte before the NACK
        send_status(STATUS_DATA_NACK, 8'h00);
        send_status(8'h00, 8'h00);
        send_status(8'hFF, 8'hFF);
        send_status(8'h09, 8'hAA);
        send_status(8'h57, 8'h55);

        run_phase(38, 61, 8'h00);
        run_phase(61, 38, 8'hFF);
        run_phase(0, 0, 8'($urandom_range(255)));

        wait_drained();
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* i2c_temp_sensor_read_sequencer.f */
hw/rtl/i2cts_pkg.sv
hw/rtl/i2cts_format.sv
hw/rtl/i2cts_step.sv
hw/rtl/i2c_temp_sensor_read_sequencer.sv
hw/rtl/i2cts_checker.sv
verif/tb.sv
